FILE: rtl/plane_normal_from_three_points_assert.svh
// assertion macros for the plane normal pipeline
// no dependencies; included by the modules that check themselves
`ifndef PLANE_NORMAL_FROM_THREE_POINTS_ASSERT_SVH
`define PLANE_NORMAL_FROM_THREE_POINTS_ASSERT_SVH

// condition holds in the same cycle
`define PNF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pnf check failed");

// condition holds in the next cycle
`define PNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pnf check failed");

`endif

FILE: rtl/pnftp_pkg.sv
// constants shared by the plane normal pipeline
// no dependencies
package pnftp_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_POINTS = 3;
    localparam int ALIGN_TOP  = 30;
    localparam int SUM_WIDTH  = 62;
    localparam int ROOT_WIDTH = 31;
    localparam int OUT_WIDTH  = 32;

endpackage

FILE: rtl/plane_normal_from_three_points.sv
// unit normal of a triangle: edges, cross product, align, isqrt, divide
// depends on pnftp_pkg and plane_normal_from_three_points_assert.svh
//
// usage
//   s_ channel: one request per triangle, nine signed coordinates in s_tdata
//   m_ channel: one request per triangle, three signed normal components in
//   m_tdata and the degenerate flag in m_tuser
//   pipeline: 8 + 31 + 1 + (NORMAL_FRAC_BITS + 1) + 1 register stages, 72 at the
//   default settings
//   throughput: one triangle per cycle while m_tready stays high; the square root
//   takes one root bit per stage and each divider one quotient bit per stage
//   every stage holds a valid bit; a stage loads whenever it is empty or the
//   stage after it moves, so bubbles close up under backpressure
//   when m_tready is low the last stage holds its request and the pipeline
//   keeps filling until every stage is full, then s_tready drops
//   reset clears all valid bits; payload registers are not reset
//   degenerate triangles (zero cross product) give zero components and
//   m_tuser set
module plane_normal_from_three_points #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero fill
    input  logic [((9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // normal_x, normal_y, normal_z
    output logic [3 * pnftp_pkg::OUT_WIDTH - 1:0] m_tdata,
    // degenerate
    output logic [0:0] m_tuser
);

    localparam int NA    = pnftp_pkg::NUM_AXES;
    localparam int AT    = pnftp_pkg::ALIGN_TOP;
    localparam int SW    = pnftp_pkg::SUM_WIDTH;
    localparam int RW    = pnftp_pkg::ROOT_WIDTH;
    localparam int OW    = pnftp_pkg::OUT_WIDTH;
    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int XW    = PW + 1;
    localparam int BW    = $clog2(XW + 1);
    localparam int REMW  = RW + 3;
    localparam int QW    = NORMAL_FRAC_BITS + 1;
    localparam int NW    = AT + NORMAL_FRAC_BITS + 1;

    localparam int ST_E    = 0;
    localparam int ST_P    = 1;
    localparam int ST_X    = 2;
    localparam int ST_O    = 3;
    localparam int ST_B    = 4;
    localparam int ST_M    = 5;
    localparam int ST_Q    = 6;
    localparam int ST_S    = 7;
    localparam int ST_R0   = 8;
    localparam int ST_PREP = ST_R0 + RW;
    localparam int ST_D0   = ST_PREP + 1;
    localparam int ST_OUT  = ST_D0 + QW;
    localparam int NST     = ST_OUT + 1;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] go;

    always_comb begin
        go[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            go[i] = !vld_reg[i] || go[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (go[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (go[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = go[0];
    assign m_tvalid = vld_reg[NST-1];

    // edges
    logic signed [CW-1:0] pt [pnftp_pkg::NUM_POINTS][NA];
    logic signed [EW-1:0] u_reg [NA];
    logic signed [EW-1:0] v_reg [NA];

    always_comb begin
        for (int p = 0; p < pnftp_pkg::NUM_POINTS; p++) begin
            for (int a = 0; a < NA; a++) begin
                pt[p][a] = s_tdata[(p * NA + a) * CW +: CW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go[ST_E]) begin
            for (int a = 0; a < NA; a++) begin
                u_reg[a] <= EW'(pt[1][a]) - EW'(pt[0][a]);
                v_reg[a] <= EW'(pt[2][a]) - EW'(pt[0][a]);
            end
        end
    end

    // products
    logic signed [PW-1:0] pa_reg [NA];
    logic signed [PW-1:0] pb_reg [NA];

    always_ff @(posedge aclk) begin
        if (go[ST_P]) begin
            pa_reg[0] <= PW'(u_reg[1]) * PW'(v_reg[2]);
            pb_reg[0] <= PW'(u_reg[2]) * PW'(v_reg[1]);
            pa_reg[1] <= PW'(u_reg[2]) * PW'(v_reg[0]);
            pb_reg[1] <= PW'(u_reg[0]) * PW'(v_reg[2]);
            pa_reg[2] <= PW'(u_reg[0]) * PW'(v_reg[1]);
            pb_reg[2] <= PW'(u_reg[1]) * PW'(v_reg[0]);
        end
    end

    // cross product
    logic signed [XW-1:0] w_reg [NA];

    always_ff @(posedge aclk) begin
        if (go[ST_X]) begin
            for (int a = 0; a < NA; a++) begin
                w_reg[a] <= XW'(pa_reg[a]) - XW'(pb_reg[a]);
            end
        end
    end

    // sign and magnitude
    logic [XW-1:0] mag_reg [NA];
    logic [NA-1:0] neg_o_reg;
    logic [XW-1:0] or_reg;
    logic [XW-1:0] mag_next [NA];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            mag_next[a] = w_reg[a][XW-1] ? XW'(unsigned'(-w_reg[a])) : XW'(unsigned'(w_reg[a]));
        end
    end

    always_ff @(posedge aclk) begin
        if (go[ST_O]) begin
            for (int a = 0; a < NA; a++) begin
                mag_reg[a]   <= mag_next[a];
                neg_o_reg[a] <= w_reg[a][XW-1];
            end
            or_reg <= mag_next[0] | mag_next[1] | mag_next[2];
        end
    end

    // bit length of the largest magnitude
    logic [XW-1:0] mag_b_reg [NA];
    logic [NA-1:0] neg_b_reg;
    logic [BW-1:0] len_b_reg;
    logic          deg_b_reg;
    logic [BW-1:0] len_next;

    always_comb begin
        len_next = '0;
        for (int i = 0; i < XW; i++) begin
            if (or_reg[i]) begin
                len_next = BW'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go[ST_B]) begin
            mag_b_reg <= mag_reg;
            neg_b_reg <= neg_o_reg;
            len_b_reg <= len_next;
            deg_b_reg <= (or_reg == '0);
        end
    end

    // align so the largest has its top bit at AT - 1
    logic [AT-1:0] m_m_reg [NA];
    logic [NA-1:0] neg_m_reg;
    logic          deg_m_reg;

    always_ff @(posedge aclk) begin
        if (go[ST_M]) begin
            for (int a = 0; a < NA; a++) begin
                m_m_reg[a] <= AT'({mag_b_reg[a], {AT{1'b0}}} >> len_b_reg);
            end
            neg_m_reg <= neg_b_reg;
            deg_m_reg <= deg_b_reg;
        end
    end

    // squares
    logic [2*AT-1:0] sq_reg [NA];
    logic [AT-1:0]   m_q_reg [NA];
    logic [NA-1:0]   neg_q_reg;
    logic            deg_q_reg;

    always_ff @(posedge aclk) begin
        if (go[ST_Q]) begin
            for (int a = 0; a < NA; a++) begin
                sq_reg[a] <= (2 * AT)'(m_m_reg[a]) * (2 * AT)'(m_m_reg[a]);
            end
            m_q_reg   <= m_m_reg;
            neg_q_reg <= neg_m_reg;
            deg_q_reg <= deg_m_reg;
        end
    end

    // sum of squares
    logic [SW-1:0] sum_reg;
    logic [AT-1:0] m_s_reg [NA];
    logic [NA-1:0] neg_s_reg;
    logic          deg_s_reg;

    always_ff @(posedge aclk) begin
        if (go[ST_S]) begin
            sum_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            m_s_reg   <= m_q_reg;
            neg_s_reg <= neg_q_reg;
            deg_s_reg <= deg_q_reg;
        end
    end

    // integer square root, one root bit per stage
    logic [SW-1:0]   sr_s_reg    [RW];
    logic [REMW-1:0] sr_rem_reg  [RW];
    logic [RW-1:0]   sr_root_reg [RW];
    logic [AT-1:0]   sr_m_reg    [RW][NA];
    logic [NA-1:0]   sr_neg_reg  [RW];
    logic            sr_deg_reg  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [SW-1:0]   s_in;
        logic [REMW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [AT-1:0]   m_in [NA];
        logic [NA-1:0]   neg_in;
        logic            deg_in;
        logic [REMW-1:0] r;
        logic [REMW-1:0] trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign s_in    = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign m_in    = m_s_reg;
            assign neg_in  = neg_s_reg;
            assign deg_in  = deg_s_reg;
        end else begin : g_next
            assign s_in    = sr_s_reg[j-1];
            assign rem_in  = sr_rem_reg[j-1];
            assign root_in = sr_root_reg[j-1];
            assign m_in    = sr_m_reg[j-1];
            assign neg_in  = sr_neg_reg[j-1];
            assign deg_in  = sr_deg_reg[j-1];
        end

        assign r     = {rem_in[REMW-3:0], s_in[SW-1-2*j -: 2]};
        assign trial = REMW'({root_in, 2'b01});
        assign ge    = (r >= trial);

        always_ff @(posedge aclk) begin
            if (go[ST_R0 + j]) begin
                sr_s_reg[j]    <= s_in;
                sr_rem_reg[j]  <= ge ? (r - trial) : r;
                sr_root_reg[j] <= {root_in[RW-2:0], ge};
                sr_m_reg[j]    <= m_in;
                sr_neg_reg[j]  <= neg_in;
                sr_deg_reg[j]  <= deg_in;
            end
        end
    end

    // dividend with rounding term
    logic [NW-1:0] num_reg [NA];
    logic [RW-1:0] len_p_reg;
    logic [NA-1:0] neg_p_reg;
    logic          deg_p_reg;

    always_ff @(posedge aclk) begin
        if (go[ST_PREP]) begin
            for (int a = 0; a < NA; a++) begin
                num_reg[a] <= NW'({sr_m_reg[RW-1][a], {NORMAL_FRAC_BITS{1'b0}}})
                            + NW'(sr_root_reg[RW-1] >> 1);
            end
            len_p_reg <= sr_root_reg[RW-1];
            neg_p_reg <= sr_neg_reg[RW-1];
            deg_p_reg <= sr_deg_reg[RW-1];
        end
    end

    // restoring division, one quotient bit per stage
    logic [NW-1:0] dv_num_reg [QW][NA];
    logic [RW-1:0] dv_rem_reg [QW][NA];
    logic [QW-1:0] dv_q_reg   [QW][NA];
    logic [RW-1:0] dv_len_reg [QW];
    logic [NA-1:0] dv_neg_reg [QW];
    logic          dv_deg_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [NW-1:0] num_in [NA];
        logic [RW-1:0] rem_in [NA];
        logic [QW-1:0] q_in   [NA];
        logic [RW-1:0] len_in;
        logic [NA-1:0] neg_in;
        logic          deg_in;
        logic [RW:0]   r      [NA];
        logic [NA-1:0] ge;

        if (k == 0) begin : g_first
            assign num_in = num_reg;
            assign len_in = len_p_reg;
            assign neg_in = neg_p_reg;
            assign deg_in = deg_p_reg;
            for (genvar a = 0; a < NA; a++) begin : g_lane
                assign rem_in[a] = RW'(num_reg[a][NW-1:QW]);
                assign q_in[a]   = '0;
            end
        end else begin : g_next
            assign num_in = dv_num_reg[k-1];
            assign rem_in = dv_rem_reg[k-1];
            assign q_in   = dv_q_reg[k-1];
            assign len_in = dv_len_reg[k-1];
            assign neg_in = dv_neg_reg[k-1];
            assign deg_in = dv_deg_reg[k-1];
        end

        always_comb begin
            for (int a = 0; a < NA; a++) begin
                r[a]  = {rem_in[a], num_in[a][QW-1-k]};
                ge[a] = (r[a] >= {1'b0, len_in});
            end
        end

        always_ff @(posedge aclk) begin
            if (go[ST_D0 + k]) begin
                for (int a = 0; a < NA; a++) begin
                    dv_rem_reg[k][a] <= ge[a] ? RW'(r[a] - {1'b0, len_in}) : RW'(r[a]);
                    dv_q_reg[k][a]   <= QW'({q_in[a], ge[a]});
                end
                dv_num_reg[k] <= num_in;
                dv_len_reg[k] <= len_in;
                dv_neg_reg[k] <= neg_in;
                dv_deg_reg[k] <= deg_in;
            end
        end
    end

    // sign and output register
    logic [OW-1:0] out_reg [NA];
    logic          out_deg_reg;

    always_ff @(posedge aclk) begin
        if (go[ST_OUT]) begin
            for (int a = 0; a < NA; a++) begin
                if (dv_deg_reg[QW-1]) begin
                    out_reg[a] <= '0;
                end else if (dv_neg_reg[QW-1][a]) begin
                    out_reg[a] <= OW'(0) - OW'(dv_q_reg[QW-1][a]);
                end else begin
                    out_reg[a] <= OW'(dv_q_reg[QW-1][a]);
                end
            end
            out_deg_reg <= dv_deg_reg[QW-1];
        end
    end

    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser = out_deg_reg;

    // helpers for the checks below
    logic root_top_ok;
    logic q_in_range;

    assign root_top_ok = (sr_root_reg[RW-1][RW-1:AT-1] != '0);

    always_comb begin
        q_in_range = 1'b1;
        for (int a = 0; a < NA; a++) begin
            if (dv_q_reg[QW-1][a] > (QW'(1) << NORMAL_FRAC_BITS)) begin
                q_in_range = 1'b0;
            end
        end
    end

`include "plane_normal_from_three_points_assert.svh"

    `PNF_ASSERT_IMPLY(a_deg_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `PNF_ASSERT_IMPLY(a_root_range, aclk, aresetn, vld_reg[ST_PREP-1] && !sr_deg_reg[RW-1], root_top_ok)
    `PNF_ASSERT_IMPLY(a_q_bound, aclk, aresetn, vld_reg[ST_OUT-1] && !dv_deg_reg[QW-1], q_in_range)
    `PNF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

FILE: verif/tb_plane_normal_from_three_points.sv
// self-checking bench for plane_normal_from_three_points: random and directed triangles,
// normals predicted in-bench and compared in order; depends on the rtl top and pnftp_pkg
module tb_plane_normal_from_three_points;
    localparam int CW = 24;
    localparam int FB = 30;
    localparam int DW = ((9 * CW + 7) / 8) * 8;
    localparam int OW = pnftp_pkg::OUT_WIDTH;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        coord_t c[9];
    } tri_t;
    typedef struct {
        logic [OW-1:0] n[3];
        logic          degen;
    } normal_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [3*OW-1:0] m_tdata;
    logic [0:0]    m_tuser;

    tri_t    pending_tris[$];
    normal_t expected_normals[$];
    string   axis_names[3] = '{"x", "y", "z"};
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      errors = 0;
    int      checked = 0;
    int      degen_seen = 0;
    longint  cycles = 0;

    plane_normal_from_three_points #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic normal_t predict_normal(logic [DW-1:0] d);
        longint u[3];
        longint v[3];
        longint w[3];
        logic [63:0] mag[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        int top;
        int shift;
        normal_t r;
        for (int a = 0; a < 3; a++) begin
            u[a] = longint'(coord_t'(d[(3+a)*CW +: CW])) - longint'(coord_t'(d[a*CW +: CW]));
            v[a] = longint'(coord_t'(d[(6+a)*CW +: CW])) - longint'(coord_t'(d[a*CW +: CW]));
        end
        w[0] = u[1] * v[2] - u[2] * v[1];
        w[1] = u[2] * v[0] - u[0] * v[2];
        w[2] = u[0] * v[1] - u[1] * v[0];
        top = 0;
        for (int a = 0; a < 3; a++) begin
            mag[a] = (w[a] < 0) ? 64'(-w[a]) : 64'(w[a]);
            for (int b = 0; b < 64; b++) if (mag[a][b] && b + 1 > top) top = b + 1;
        end
        r.degen = (top == 0);
        if (top == 0) begin
            for (int a = 0; a < 3; a++) r.n[a] = '0;
            return r;
        end
        shift = top - pnftp_pkg::ALIGN_TOP;
        sum = 0;
        for (int a = 0; a < 3; a++) begin
            mag[a] = (shift > 0) ? (mag[a] >> shift) : (mag[a] << (-shift));
            sum = sum + mag[a] * mag[a];
        end
        len = int_sqrt(sum);
        for (int a = 0; a < 3; a++) begin
            q = ((mag[a] << FB) + (len >> 1)) / len;
            r.n[a] = (w[a] < 0) ? OW'(-q) : OW'(q);
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] pack_tri(tri_t t);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*CW +: CW] = t.c[i];
        return d;
    endfunction

    function automatic tri_t make_tri(int c0, int c1, int c2, int c3, int c4, int c5,
                                      int c6, int c7, int c8);
        tri_t t;
        t.c[0] = coord_t'(c0); t.c[1] = coord_t'(c1); t.c[2] = coord_t'(c2);
        t.c[3] = coord_t'(c3); t.c[4] = coord_t'(c4); t.c[5] = coord_t'(c5);
        t.c[6] = coord_t'(c6); t.c[7] = coord_t'(c7); t.c[8] = coord_t'(c8);
        return t;
    endfunction

    function automatic void add_tri(tri_t t);
        pending_tris = {pending_tris, t};
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int kind;
        int k;
        int dv;
        kind = int'($urandom_range(0, 9));
        for (int i = 0; i < 9; i++) t.c[i] = coord_t'($urandom);
        if (kind < 2) begin
            // collinear or coincident
            k = int'($urandom_range(0, 16)) - 8;
            for (int a = 0; a < 3; a++) begin
                t.c[a] = coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
                dv = int'($urandom_range(0, 2048)) - 1024;
                t.c[3+a] = coord_t'(int'(t.c[a]) + dv);
                t.c[6+a] = coord_t'(int'(t.c[a]) + k * dv);
            end
        end else if (kind < 4) begin
            // flat in one axis
            k = int'($urandom_range(0, 2));
            t.c[3+k] = t.c[k];
            t.c[6+k] = t.c[k];
        end else if (kind < 6) begin
            for (int i = 0; i < 9; i++)
                t.c[i] = coord_t'(int'($urandom_range(0, 64)) - 32);
        end else if (kind == 6) begin
            for (int i = 0; i < 9; i++)
                t.c[i] = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        end
        return t;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_tris.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                s_tdata  <= pack_tri(pending_tris.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin
        normal_t e;
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (s_tvalid && s_tready) begin
                expected_normals = {expected_normals, predict_normal(s_tdata)};
            end
            if (m_tvalid && m_tready) begin
                if (expected_normals.size() == 0) begin
                    $error("result with no request pending");
                    errors = errors + 1;
                end else begin
                    e = expected_normals.pop_front();
                    checked <= checked + 1;
                    if (e.degen) degen_seen <= degen_seen + 1;
                    for (int a = 0; a < 3; a++) begin
                        if (m_tdata[a*OW +: OW] !== e.n[a]) begin
                            $error("normal_%s expected %0d actual %0d", axis_names[a],
                                   $signed(e.n[a]), $signed(m_tdata[a*OW +: OW]));
                            errors = errors + 1;
                        end
                    end
                    if (m_tuser[0] !== e.degen) begin
                        $error("degenerate expected %0d actual %0d", e.degen, m_tuser[0]);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_tri(make_tri(5, -3, 9, 5, -3, 9, 5, -3, 9));
        add_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        add_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        add_tri(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0));
        add_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        add_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        add_tri(make_tri(7, 7, 7, 7, 8, 7, 7, 7, 6));
        add_tri(make_tri(-8388608, -8388608, -8388608, 8388607, -8388608,
                         -8388608, -8388608, 8388607, 8388607));
        add_tri(make_tri(8388607, 8388607, 8388607, -8388608, 8388607,
                         8388607, 8388607, -8388608, 8388607));
        add_tri(make_tri(-8388608, 0, 8388607, 8388607, -8388608, 0,
                         0, 8388607, -8388608));
        add_tri(make_tri(-1, -1, -1, -1, -1, -1, 0, 0, 0));
        add_tri(make_tri(1, 2, 3, 4, 6, 9, 7, 1, 2));
        add_tri(make_tri(-8388608, -8388608, 0, 8388607, -8388608, 0,
                         -8388608, 8388607, 0));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            for (int i = 0; i < 185; i++) add_tri(random_tri());
            while (pending_tris.size() > 0 || s_tvalid) @(posedge aclk);
            // hold off until the pipeline has drained
            while (expected_normals.size() > 0) @(posedge aclk);
        end

        repeat (100) @(posedge aclk);
        $display("checked %0d triangle normals, %0d of them degenerate, across four",
                 checked, degen_seen);
        $display("handshake phases with idle sender, stalled receiver and both");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
